### sv/assert_macros.svh
// Assertion macros used by the point-in-polygon top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/pip_pkg.sv
// Types and constants for the point-in-polygon crossing test.
`timescale 1ns / 1ps

package pip_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int MAX_VERTICES = 4096;
   localparam int CNT_WIDTH    = $clog2(MAX_VERTICES + 1);
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;
   localparam int SUM_WIDTH    = PROD_WIDTH + 1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [SUM_WIDTH-1:0]   sum_type;
   typedef logic [CNT_WIDTH-1:0]          count_type;
   typedef logic [CNT_WIDTH:0]            count_ext_type;

   typedef enum logic {
      CSR_POINT_X = 1'b0,
      CSR_POINT_Y = 1'b1
   } csr_index_type;

   // Differences of one edge, ready for cross multiplication
   typedef struct packed {
      logic     active;
      logic     d_neg;
      diff_type dy;
      diff_type xb;
      diff_type yb;
      diff_type d;
   } edge_diff_type;

   typedef struct packed {
      logic     active;
      logic     d_neg;
      prod_type p0;
      prod_type p1;
   } edge_prod_type;

endpackage

### sv/point_in_polygon_crossing_test.sv
// Point-in-polygon crossing-number test: top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   Write the query point through the csr_ channel (index 0 = x, 1 = y)
//   while the block is idle; csr_ready is always high.
//   Send polygon vertices on the req_ channel, one item per cycle, with
//   req_last_vertex set on the final vertex. The block closes the polygon
//   with an edge back to the first vertex itself.
//   For each last vertex one item leaves on rsp_: rsp_inside_res (odd
//   crossing parity) and rsp_crossings (count, saturating at 4096).
// Timing
//   Three register stages: difference, product, accumulate/result.
//   The last vertex passes the difference, product and result registers before its result appears.
//   Throughput is one vertex per cycle while req_stall is low, set by the four 17x17
//   multipliers in the product stage, which all edges share in a pipelined fashion.
// Reset and stall
//   Synchronous reset clears the pipeline, the polygon state and the
//   query point. A stalled result holds in the output register; bubbles
//   ahead of it keep filling, and req_stall rises only once the stage
//   behind the input register is full.
module point_in_polygon_crossing_test (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  pip_pkg::coord_type       req_vertex_x,
   input  pip_pkg::coord_type       req_vertex_y,
   input  logic                     req_last_vertex,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_inside_res,
   output pip_pkg::count_type       rsp_crossings,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic                     csr_index,
   input  pip_pkg::coord_type       csr_wdata
);

   pip_pkg::coord_type     px_ff, px_in, py_ff, py_in;
   pip_pkg::coord_type     first_x_ff, first_x_in, first_y_ff, first_y_in;
   pip_pkg::coord_type     prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic                   have_vertex_ff, have_vertex_in;

   logic                   s1_valid_ff, s1_valid_in;
   logic                   s1_first_ff, s1_first_in, s1_last_ff, s1_last_in;
   pip_pkg::edge_diff_type s1_a_ff, s1_a_in, s1_b_ff, s1_b_in;

   logic                   s2_valid_ff, s2_valid_in;
   logic                   s2_first_ff, s2_first_in, s2_last_ff, s2_last_in;
   pip_pkg::edge_prod_type s2_a_ff, s2_a_in, s2_b_ff, s2_b_in;

   pip_pkg::count_type     cnt_ff, cnt_in;
   logic                   odd_ff, odd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_inside_ff, rsp_inside_in;
   pip_pkg::count_type     rsp_crossings_ff, rsp_crossings_in;

   logic                   rsp_free, s2_go, s2_open, s1_go, s1_open, req_take;
   logic                   hit_a, hit_b, base_odd;
   pip_pkg::count_type     base_cnt;
   pip_pkg::count_ext_type cnt_sum;
   pip_pkg::coord_type     close_x, close_y;

   function automatic pip_pkg::edge_diff_type edge_diff(
      input logic               en,
      input pip_pkg::coord_type ax,
      input pip_pkg::coord_type ay,
      input pip_pkg::coord_type bx,
      input pip_pkg::coord_type by,
      input pip_pkg::coord_type qx,
      input pip_pkg::coord_type qy
   );
      pip_pkg::edge_diff_type e;
      pip_pkg::diff_type      axw, ayw, bxw, byw, qxw, qyw;
      logic                   between;
      axw = pip_pkg::diff_type'(ax);
      ayw = pip_pkg::diff_type'(ay);
      bxw = pip_pkg::diff_type'(bx);
      byw = pip_pkg::diff_type'(by);
      qxw = pip_pkg::diff_type'(qx);
      qyw = pip_pkg::diff_type'(qy);
      between  = ((qx > ax) && (qx < bx)) || ((qx < ax) && (qx > bx));
      e.active = en && between;
      e.d_neg  = bx < ax;
      e.dy     = byw - ayw;
      e.xb     = qxw - bxw;
      e.yb     = byw - qyw;
      e.d      = bxw - axw;
      return e;
   endfunction

   function automatic pip_pkg::edge_prod_type edge_prod(
      input pip_pkg::edge_diff_type e
   );
      pip_pkg::edge_prod_type p;
      p.active = e.active;
      p.d_neg  = e.d_neg;
      p.p0     = pip_pkg::prod_type'($signed(e.dy)) * pip_pkg::prod_type'($signed(e.xb));
      p.p1     = pip_pkg::prod_type'($signed(e.yb)) * pip_pkg::prod_type'($signed(e.d));
      return p;
   endfunction

   // Edge lies above the point when the sign of the cross sum matches the sign of d
   function automatic logic edge_hit(input pip_pkg::edge_prod_type p);
      pip_pkg::sum_type s;
      s = pip_pkg::sum_type'($signed(p.p0)) + pip_pkg::sum_type'($signed(p.p1));
      return p.active && (p.d_neg ? (s < 0) : (s > 0));
   endfunction

   // Handshake: each stage advances when the one behind it is free
   always_comb begin
      rsp_free = !rsp_valid_ff || !rsp_stall;
      s2_go    = s2_valid_ff && (!s2_last_ff || rsp_free);
      s2_open  = !s2_valid_ff || s2_go;
      s1_go    = s1_valid_ff && s2_open;
      s1_open  = !s1_valid_ff || s2_open;
      req_take = req_valid && s1_open;
   end

   // Configuration
   always_comb begin
      px_in = px_ff;
      py_in = py_ff;
      if (csr_valid) begin
         case (pip_pkg::csr_index_type'(csr_index))
            pip_pkg::CSR_POINT_X: px_in = csr_wdata;
            pip_pkg::CSR_POINT_Y: py_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: polygon state and edge differences
   always_comb begin
      first_x_in     = first_x_ff;
      first_y_in     = first_y_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      have_vertex_in = have_vertex_ff;
      close_x        = have_vertex_ff ? first_x_ff : req_vertex_x;
      close_y        = have_vertex_ff ? first_y_ff : req_vertex_y;
      s1_valid_in    = s1_open ? req_valid : s1_valid_ff;
      s1_first_in    = s1_first_ff;
      s1_last_in     = s1_last_ff;
      s1_a_in        = s1_a_ff;
      s1_b_in        = s1_b_ff;
      if (req_take) begin
         prev_x_in      = req_vertex_x;
         prev_y_in      = req_vertex_y;
         first_x_in     = close_x;
         first_y_in     = close_y;
         have_vertex_in = !req_last_vertex;
         s1_first_in    = !have_vertex_ff;
         s1_last_in     = req_last_vertex;
         s1_a_in        = edge_diff(have_vertex_ff, prev_x_ff, prev_y_ff,
                                    req_vertex_x, req_vertex_y, px_ff, py_ff);
         s1_b_in        = edge_diff(req_last_vertex, req_vertex_x, req_vertex_y,
                                    close_x, close_y, px_ff, py_ff);
      end
   end

   // Product stage
   always_comb begin
      s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;
      s2_first_in = s2_first_ff;
      s2_last_in  = s2_last_ff;
      s2_a_in     = s2_a_ff;
      s2_b_in     = s2_b_ff;
      if (s1_go) begin
         s2_first_in = s1_first_ff;
         s2_last_in  = s1_last_ff;
         s2_a_in     = edge_prod(s1_a_ff);
         s2_b_in     = edge_prod(s1_b_ff);
      end
   end

   // Accumulate stage and result register
   always_comb begin
      hit_a    = edge_hit(s2_a_ff);
      hit_b    = edge_hit(s2_b_ff);
      base_cnt = s2_first_ff ? '0 : cnt_ff;
      base_odd = s2_first_ff ? 1'b0 : odd_ff;
      cnt_sum  = pip_pkg::count_ext_type'(base_cnt)
               + pip_pkg::count_ext_type'(hit_a)
               + pip_pkg::count_ext_type'(hit_b);
      cnt_in   = cnt_ff;
      odd_in   = odd_ff;
      if (s2_go) begin
         // hold the count at the maximum, parity keeps running
         if (cnt_sum > pip_pkg::count_ext_type'(pip_pkg::MAX_VERTICES)) begin
            cnt_in = pip_pkg::count_type'(pip_pkg::MAX_VERTICES);
         end else begin
            cnt_in = cnt_sum[pip_pkg::CNT_WIDTH-1:0];
         end
         odd_in = base_odd ^ hit_a ^ hit_b;
      end
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_inside_in    = rsp_inside_ff;
      rsp_crossings_in = rsp_crossings_ff;
      if (s2_go && s2_last_ff) begin
         rsp_valid_in     = 1'b1;
         rsp_inside_in    = odd_in;
         rsp_crossings_in = cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff          <= '0;
         py_ff          <= '0;
         have_vertex_ff <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         cnt_ff         <= '0;
         odd_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         px_ff          <= px_in;
         py_ff          <= py_in;
         have_vertex_ff <= have_vertex_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
         cnt_ff         <= cnt_in;
         odd_ff         <= odd_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      first_x_ff       <= first_x_in;
      first_y_ff       <= first_y_in;
      prev_x_ff        <= prev_x_in;
      prev_y_ff        <= prev_y_in;
      s1_first_ff      <= s1_first_in;
      s1_last_ff       <= s1_last_in;
      s1_a_ff          <= s1_a_in;
      s1_b_ff          <= s1_b_in;
      s2_first_ff      <= s2_first_in;
      s2_last_ff       <= s2_last_in;
      s2_a_ff          <= s2_a_in;
      s2_b_ff          <= s2_b_in;
      rsp_inside_ff    <= rsp_inside_in;
      rsp_crossings_ff <= rsp_crossings_in;
   end

   assign req_stall      = !s1_open;
   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_crossings  = rsp_crossings_ff;

   `ASSERT_IMPLY(a_count_in_range, clock, reset, rsp_valid,
      rsp_crossings <= pip_pkg::count_type'(pip_pkg::MAX_VERTICES),
      "crossing count above saturation limit")
   `ASSERT_IMPLY(a_zero_is_outside, clock, reset,
      rsp_valid && (rsp_crossings == '0), !rsp_inside_res,
      "odd parity reported with zero crossings")
   `ASSERT_NEXT(a_last_gives_result, clock, reset, s2_go && s2_last_ff, rsp_valid,
      "retired last vertex produced no result")
   `ASSERT_NEXT(a_last_closes_polygon, clock, reset, req_take && req_last_vertex,
      !have_vertex_ff, "polygon left open after its last vertex")

endmodule
